/* rtl/core/xpcf_pkg.sv */
// ----------------------------------------------------------------------------
// xpcf_pkg: shared types and constants of the payload receive filter
// Item types for both channels, register indexes and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package xpcf_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CHECK_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 1;

  localparam logic [CHECK_W-1:0] POLY_CCITT = 16'h1021;
  localparam logic [DATA_W-1:0]  CHAR_CR    = 8'h0d;
  localparam logic [DATA_W-1:0]  CHAR_CTRLZ = 8'h1a;
  localparam logic [DATA_W-1:0]  TEXT_MASK  = 8'h7f;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_MODE = 1'd1;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              packet_first;
    logic              packet_last;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] write_index;
    logic [DATA_W-1:0]  write_data;
    logic               index_advanced;
    logic [CHECK_W-1:0] check_value;
    logic [COUNT_W-1:0] kept_count;
    logic               end_of_file_seen;
    logic               last;
  } out_item_t;

  // One byte of CRC-16/XMODEM, MSB first: eight shift and conditional xor steps.
  function automatic logic [CHECK_W-1:0] crc16_step(input logic [CHECK_W-1:0] crc,
                                                    input logic [DATA_W-1:0]  b);
    logic [CHECK_W-1:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[CHECK_W-1]) begin
        r = {r[CHECK_W-2:0], 1'b0} ^ POLY_CCITT;
      end else begin
        r = {r[CHECK_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/xpcf_ifs.sv */
// ----------------------------------------------------------------------------
// xpcf channel interfaces
// Valid/ready channels for payload bytes and for filter results.
// ----------------------------------------------------------------------------
interface xpcf_in_if;
  logic               valid;
  logic               ready;
  xpcf_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface xpcf_out_if;
  logic                valid;
  logic                ready;
  xpcf_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* rtl/core/xpcf_in_reg.sv */
// ----------------------------------------------------------------------------
// xpcf_in_reg: input register
// Captures one payload byte item and holds it until the filter stage takes it.
// ----------------------------------------------------------------------------
module xpcf_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  xpcf_in_if.sink    up,
  xpcf_in_if.source  dn
);

  logic               valid_r;
  logic               valid_nxt;
  xpcf_pkg::in_item_t item_r;

  // The register may refill in the same cycle that it drains.
  assign up.ready = !valid_r || dn.ready;
  assign dn.valid = valid_r;
  assign dn.item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (up.valid && up.ready) begin
      valid_nxt = 1'b1;
    end else if (dn.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      item_r <= up.item;
    end
  end

endmodule

/* rtl/core/xpcf_proc.sv */
// ----------------------------------------------------------------------------
// xpcf_proc: filter stage and result register
// Updates check value, kept count and end-of-file flag for each byte item.
// ----------------------------------------------------------------------------
module xpcf_proc #(
  parameter int unsigned MAX_PACKET = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [xpcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xpcf_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  xpcf_in_if.sink                           up,
  xpcf_out_if.source                        dn
);

  logic                           crc_mode_r;
  logic                           text_mode_r;
  logic [xpcf_pkg::CHECK_W-1:0]   check_r;
  logic [xpcf_pkg::CHECK_W-1:0]   check_nxt;
  logic [xpcf_pkg::COUNT_W-1:0]   count_r;
  logic [xpcf_pkg::COUNT_W-1:0]   count_nxt;
  logic                           eof_r;
  logic                           eof_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  xpcf_pkg::out_item_t            out_item_r;
  xpcf_pkg::out_item_t            out_item_nxt;

  logic [xpcf_pkg::CHECK_W-1:0]   base_check;
  logic [xpcf_pkg::COUNT_W-1:0]   base_count;
  logic                           base_eof;
  logic [xpcf_pkg::DATA_W-1:0]    byte_in;
  logic [xpcf_pkg::DATA_W-1:0]    sum8;
  logic                           is_cr;
  logic                           is_ctrlz;
  logic                           full;
  logic                           keep;
  logic                           take;

  assign up.ready = !out_valid_r || dn.ready;
  assign take     = up.valid && up.ready;
  assign dn.valid = out_valid_r;
  assign dn.item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r  <= 1'b1;
      text_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xpcf_pkg::REG_CRC_MODE:  crc_mode_r  <= cfg_wdata[0];
        xpcf_pkg::REG_TEXT_MODE: text_mode_r <= cfg_wdata[0];
      endcase
    end
  end

  always_comb begin
    byte_in    = up.item.data_byte;
    base_check = up.item.packet_first ? '0 : check_r;
    base_count = up.item.packet_first ? '0 : count_r;
    base_eof   = up.item.packet_first ? 1'b0 : eof_r;
    sum8       = base_check[7:0] + byte_in;
    is_cr      = (byte_in == xpcf_pkg::CHAR_CR);
    is_ctrlz   = (byte_in == xpcf_pkg::CHAR_CTRLZ);
    full       = (32'(base_count) >= MAX_PACKET);

    if (crc_mode_r) begin
      check_nxt = xpcf_pkg::crc16_step(base_check, byte_in);
    end else begin
      check_nxt = {8'h00, sum8};
    end

    eof_nxt = base_eof || (text_mode_r && is_ctrlz);

    if (text_mode_r) begin
      keep = !is_cr && !is_ctrlz && !base_eof && !full;
    end else begin
      keep = !full;
    end

    count_nxt = base_count + xpcf_pkg::COUNT_W'(keep);

    out_item_nxt.write_index      = full ? '0 : base_count[xpcf_pkg::INDEX_W-1:0];
    out_item_nxt.write_data       = text_mode_r ? (byte_in & xpcf_pkg::TEXT_MASK) : byte_in;
    out_item_nxt.index_advanced   = keep;
    out_item_nxt.check_value      = check_nxt;
    out_item_nxt.kept_count       = count_nxt;
    out_item_nxt.end_of_file_seen = eof_nxt;
    out_item_nxt.last             = up.item.packet_last;

    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (dn.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r     <= '0;
      count_r     <= '0;
      eof_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        check_r <= check_nxt;
        count_r <= count_nxt;
        eof_r   <= eof_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

/* rtl/core/xmodem_payload_crc_filter.sv */
// ----------------------------------------------------------------------------
// xmodem_payload_crc_filter: XMODEM payload receive filter
// Running CRC-16 or checksum, kept-byte index and text-mode filtering.
// ----------------------------------------------------------------------------
// Usage:
// Payload bytes enter on in_chan, one byte per item, with packet_first on the
// first byte of a packet (it clears the check value, the kept count and the
// end-of-file flag before that byte) and packet_last on the final byte.
// Every byte item gives exactly one result item on out_chan: the buffer
// write index and data, whether the byte was kept, and the running check
// value, kept count and end-of-file flag after the byte.
// The cfg port selects CRC-16/XMODEM or the 8-bit checksum and text mode;
// write it only while no item is in flight.
// A result item is registered twice after its byte item is accepted: in the
// input register, then through the filter logic into the result register.
// Throughput is one item per cycle while out_chan.ready stays high; the limit
// is the single CRC byte step between the input register and the state
// registers.
// Reset clears both pipeline stages and the running state and selects CRC
// mode in binary mode. When the receiver holds out_chan.ready low the result
// stays in place, the input register still fills once, and then in_chan
// ready drops until the result is taken.
// ----------------------------------------------------------------------------
module xmodem_payload_crc_filter #(
  parameter int unsigned MAX_PACKET = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [xpcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xpcf_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  xpcf_in_if.sink                           in_chan,
  xpcf_out_if.source                        out_chan
);

  // Channel between the input register and the filter stage.
  xpcf_in_if stage_chan ();

  xpcf_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_chan),
    .dn    (stage_chan.source)
  );

  xpcf_proc #(
    .MAX_PACKET (MAX_PACKET)
  ) u_proc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .up        (stage_chan.sink),
    .dn        (out_chan)
  );

endmodule

/* rtl/core/xpcf_checker.sv */
// ----------------------------------------------------------------------------
// xpcf_checker: port-level checks of the payload receive filter
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module xpcf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input xpcf_pkg::out_item_t         out_item
);

  // A stalled result keeps its valid.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result item changed while stalled");

  // A kept byte moves the count to one past its own write index.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.index_advanced |->
      out_item.kept_count[xpcf_pkg::INDEX_W-1:0] == out_item.write_index + 10'd1)
    else $error("kept count does not follow write index");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind xmodem_payload_crc_filter xpcf_checker u_xpcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.item)
);

/* verif/xpcf_filter_checker.sv */
// ----------------------------------------------------------------------------
// xpcf_filter_checker: result predictor and comparator for the payload filter
// Watches both channels and the register port. It predicts the filter result
// of every accepted byte and compares each result item field by field.
// ----------------------------------------------------------------------------
module xpcf_filter_checker #(
  parameter int unsigned MAX_KEEP = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xpcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xpcf_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  xpcf_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  xpcf_pkg::out_item_t            out_item,
  output int                             outstanding,
  output int                             mismatches
);
  import xpcf_pkg::*;

  // Shadow registers and running state of the filter.
  logic               crc_on;
  logic               text_on;
  logic [CHECK_W-1:0] run_check;
  logic [COUNT_W-1:0] run_kept;
  logic               run_eof;

  out_item_t pending_results[$];
  out_item_t oldest;
  int        errors = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Bit-serial CRC-16/XMODEM over one byte, MSB first.
  function automatic logic [CHECK_W-1:0] crc_update(input logic [CHECK_W-1:0] crc,
                                                    input logic [DATA_W-1:0]  b);
    logic [CHECK_W-1:0] r;
    logic               fb;
    r = crc;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      fb = r[CHECK_W-1] ^ b[i];
      r  = {r[CHECK_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ POLY_CCITT;
      end
    end
    return r;
  endfunction

  function automatic out_item_t filter_byte(input in_item_t b);
    out_item_t         r;
    logic              full;
    logic              keep;
    logic [DATA_W-1:0] d;
    if (b.packet_first) begin
      run_check = '0;
      run_kept  = '0;
      run_eof   = 1'b0;
    end
    if (crc_on) begin
      run_check = crc_update(run_check, b.data_byte);
    end else begin
      run_check = {8'h00, run_check[7:0] + b.data_byte};
    end
    full          = (run_kept >= MAX_KEEP);
    r.write_index = full ? '0 : run_kept[INDEX_W-1:0];
    d             = b.data_byte;
    keep          = 1'b1;
    if (text_on) begin
      // CR and CTRL-Z are matched on the raw byte, before bit 7 is cleared.
      d = b.data_byte & TEXT_MASK;
      if (b.data_byte == CHAR_CR) begin
        keep = 1'b0;
      end else if (b.data_byte == CHAR_CTRLZ) begin
        run_eof = 1'b1;
        keep    = 1'b0;
      end else begin
        keep = !run_eof;
      end
    end
    if (full) begin
      keep = 1'b0;
    end
    if (keep) begin
      run_kept = run_kept + 1'b1;
    end
    r.write_data       = d;
    r.index_advanced   = keep;
    r.check_value      = run_check;
    r.kept_count       = run_kept;
    r.end_of_file_seen = run_eof;
    r.last             = b.packet_last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      crc_on    = 1'b1;
      text_on   = 1'b0;
      run_check = '0;
      run_kept  = '0;
      run_eof   = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CRC_MODE:  crc_on  = cfg_wdata[0];
          REG_TEXT_MODE: text_on = cfg_wdata[0];
          default: ;
        endcase
      end
      // A result can never belong to a byte accepted at the same edge.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result item with no byte waiting for it");
        end else begin
          oldest = pending_results.pop_front();
          check_field("write_index", 32'(out_item.write_index),
                      32'(oldest.write_index));
          check_field("write_data", 32'(out_item.write_data),
                      32'(oldest.write_data));
          check_field("index_advanced", 32'(out_item.index_advanced),
                      32'(oldest.index_advanced));
          check_field("check_value", 32'(out_item.check_value),
                      32'(oldest.check_value));
          check_field("kept_count", 32'(out_item.kept_count),
                      32'(oldest.kept_count));
          check_field("end_of_file_seen", 32'(out_item.end_of_file_seen),
                      32'(oldest.end_of_file_seen));
          check_field("last", 32'(out_item.last), 32'(oldest.last));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(filter_byte(in_item));
      end
    end
    outstanding <= pending_results.size();
    mismatches  <= errors;
  end

endmodule

/* verif/tb_xmodem_payload_crc_filter.sv */
// ----------------------------------------------------------------------------
// tb_xmodem_payload_crc_filter: testbench of the XMODEM payload filter
// Drives payload bytes through the filter in all four mode settings, with
// random gaps and stalls, a long receiver hold-off and a packet that fills
// the buffer. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_xmodem_payload_crc_filter;
  import xpcf_pkg::*;

  localparam int unsigned MAX_PACKET   = 1024;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          PHASE_ITEMS  = 95;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  xpcf_in_if  in_chan ();
  xpcf_out_if out_chan ();

  int outstanding;
  int mismatches;

  // Idling controls shared between the stimulus and the receiver.
  bit idle_in  = 1'b0;
  bit idle_out = 1'b0;
  bit hold_req = 1'b0;
  bit text_now = 1'b0;
  int quiet_cycles = 0;

  xmodem_payload_crc_filter #(
    .MAX_PACKET (MAX_PACKET)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan.sink),
    .out_chan  (out_chan.source)
  );

  xpcf_filter_checker #(
    .MAX_KEEP (MAX_PACKET)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_item     (in_chan.item),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_item    (out_chan.item),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #5 clk = ~clk;

  // The watchdog ends the run if no item moves on either channel for too long.
  // The longest correct silence is the receiver hold-off plus one gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: before each result item it draws a stall. A hold-off request
  // from the stimulus replaces the stall with a long stretch of ready low,
  // so that the block fills its two stages and drops in_chan.ready.
  initial begin
    int  stall;
    bit  took;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = idle_out ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      // Handshake signals only change at the rising edge, so the value seen
      // at the falling edge is the one the next rising edge acts on.
      do begin
        @(negedge clk);
        took = out_chan.valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // Both registers are written in consecutive cycles, with the write enable
  // held high across the pair.
  task automatic set_modes(input bit crc, input bit text);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CRC_MODE;
    cfg_wdata <= crc;
    @(posedge clk);
    cfg_index <= REG_TEXT_MODE;
    cfg_wdata <= text;
    @(posedge clk);
    cfg_we   <= 1'b0;
    text_now = text;
  endtask

  // Offers one byte item and returns at the edge that accepts it. Valid stays
  // high into the next item when no gap is drawn.
  task automatic send_byte(input logic [7:0] d, input bit first, input bit last);
    int gap;
    bit took;
    in_item_t it;
    gap = idle_in ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte    = d;
    it.packet_first = first;
    it.packet_last  = last;
    in_chan.valid <= 1'b1;
    in_chan.item  <= it;
    do begin
      @(negedge clk);
      took = in_chan.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Stops offering and waits until every predicted result has been taken,
  // then lets the two pipeline stages settle.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Random payload content. In text mode the bytes that the filter treats
  // specially, and their bit-7 look-alikes, come up more often.
  function automatic logic [7:0] pick_byte();
    logic [7:0] specials [8] = '{8'h0d, 8'h1a, 8'h8d, 8'h9a, 8'h00, 8'hff, 8'h7f, 8'h80};
    if ($urandom_range(0, text_now ? 9 : 19) == 0) begin
      return specials[$urandom_range(0, 7)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // One well-formed packet. When pause_at names a byte, the sender stops
  // before it until everything in flight has come out.
  task automatic send_packet(input int len, input int pause_at, inout int sent);
    for (int k = 0; k < len; k++) begin
      if (k == pause_at) begin
        wait_drained();
      end
      send_byte(pick_byte(), k == 0, k == len - 1);
      sent++;
    end
  endtask

  initial begin
    int sent;
    int len;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CRC_MODE;
    cfg_wdata      <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.item   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, binary CRC mode: the byte extremes and the bytes that
    // only matter in text mode, which must be kept unchanged here.
    set_modes(1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h0d, 1'b0, 1'b0);
    send_byte(8'h1a, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b1);
    wait_drained();

    // Text mode with the additive checksum: CR dropped, 0x8d and 0x9a kept as
    // ordinary bytes with bit 7 cleared, CTRL-Z ending the kept data.
    set_modes(1'b0, 1'b1);
    send_byte(8'h41, 1'b1, 1'b0);
    send_byte(8'h0d, 1'b0, 1'b0);
    send_byte(8'h8d, 1'b0, 1'b0);
    send_byte(8'h9a, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h1a, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h0d, 1'b0, 1'b0);
    send_byte(8'h1a, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    wait_drained();

    // End of file seen in text mode, then binary mode in the middle of the
    // packet: the flag stays set but no longer stops bytes from being kept.
    set_modes(1'b1, 1'b1);
    send_byte(8'h42, 1'b1, 1'b0);
    send_byte(8'h1a, 1'b0, 1'b0);
    wait_drained();
    set_modes(1'b0, 1'b0);
    send_byte(8'h43, 1'b0, 1'b0);
    send_byte(8'h1a, 1'b0, 1'b1);
    // A one-byte packet, first and last at once, clears the flag again.
    send_byte(8'hfe, 1'b1, 1'b1);
    wait_drained();

    // Random phases over all four settings. Phase 2 runs without idling on
    // either side, phase 3 holds the receiver off, phase 5 pauses the sender
    // in the middle of a packet until every result has come.
    for (int ph = 0; ph < 8; ph++) begin
      set_modes(ph[0], ph[1]);
      idle_in  = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      idle_out = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: packet markers in arbitrary places.
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 130) : $urandom_range(1, 24);
          send_packet(len, (ph == 5 && sent == 0) ? len / 2 : -1, sent);
        end
      end
      wait_drained();
    end

    // One packet longer than the buffer: the kept count saturates and the
    // write index drops to zero once the buffer is full.
    set_modes(1'b0, 1'b0);
    idle_in  = 1'b0;
    idle_out = 1'b1;
    sent = 0;
    send_packet(MAX_PACKET + 6, -1, sent);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/xpcf_pkg.sv
rtl/core/xpcf_ifs.sv
rtl/core/xpcf_in_reg.sv
rtl/core/xpcf_proc.sv
rtl/core/xmodem_payload_crc_filter.sv
rtl/core/xpcf_checker.sv
verif/xpcf_filter_checker.sv
verif/tb_xmodem_payload_crc_filter.sv
